/* sv/rwbp_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rwbp_pkg
// Shared types, codes and constants of the register write blob parser.
// ---------------------------------------------------------------------------
package rwbp_pkg;

	localparam int unsigned WORD_W = 24;
	localparam int unsigned SUM_W  = WORD_W + 2;

	localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

	localparam logic [WORD_W-1:0] HEAD_LEN  = WORD_W'(12);
	localparam logic [WORD_W-1:0] MAGIC_LEN = WORD_W'(7);
	localparam logic [WORD_W-1:0] ACT_LEN   = WORD_W'(6);

	// parse phases
	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_ACTION  = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_PAD     = 3'd3;
	localparam logic [2:0] PH_DRAIN   = 3'd4;

	// result kinds
	localparam logic [2:0] KIND_WRITE    = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
	localparam logic [2:0] KIND_SAFELOAD = 3'd2;
	localparam logic [2:0] KIND_DONE     = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	// error codes
	localparam logic [2:0] ERR_HEADER    = 3'd0;
	localparam logic [2:0] ERR_SHORT_LEN = 3'd1;
	localparam logic [2:0] ERR_TRUNC     = 3'd2;
	localparam logic [2:0] ERR_TYPE      = 3'd3;
	localparam logic [2:0] ERR_NO_END    = 3'd4;

	// action types
	localparam logic [7:0] TYPE_SAFELOAD = 8'd2;
	localparam logic [7:0] TYPE_END      = 8'd3;

	typedef struct packed {
		logic [2:0]        kind;
		logic [15:0]       reg_addr;
		logic [WORD_W-1:0] payload_length;
		logic [7:0]        data_byte;
		logic              last_of_write;
		logic [2:0]        error_code;
		logic [WORD_W-1:0] blob_offset;
	} res_t;

	// up to two results produced by one accepted byte, in order
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h41; // A
			3'd1: c = 8'h44; // D
			3'd2: c = 8'h49; // I
			3'd3: c = 8'h53; // S
			3'd4: c = 8'h49; // I
			3'd5: c = 8'h47; // G
			3'd6: c = 8'h4D; // M
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [WORD_W-1:0] sat_off(input logic [SUM_W-1:0] v);
		logic [WORD_W-1:0] r;
		if (v > SUM_W'(WORD_MAX)) r = WORD_MAX;
		else r = v[WORD_W-1:0];
		return r;
	endfunction

	function automatic res_t mk_res(
		input logic [2:0]        kind,
		input logic [15:0]       addr,
		input logic [WORD_W-1:0] plen,
		input logic [7:0]        data,
		input logic              last,
		input logic [2:0]        err,
		input logic [WORD_W-1:0] off
	);
		res_t r;
		r.kind           = kind;
		r.reg_addr       = addr;
		r.payload_length = plen;
		r.data_byte      = data;
		r.last_of_write  = last;
		r.error_code     = err;
		r.blob_offset    = off;
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/register_write_blob_parser_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// register_write_blob_parser_unit
// Streams a firmware blob one byte per beat and reports register writes.
// ---------------------------------------------------------------------------
// Results: the results of an accepted byte are registered in the result queue and leave from its head in order.
// Throughput: one byte per cycle; the decode is a single pass over the
// parser state. A byte with two results takes two output beats, and the
// four-entry result queue holds input off while more than two are queued.
// Input is also held off in a cycle that offers a blob_length write.
// Reset: arst_n clears the parser to header phase and blob_length to zero;
// a blob_length write also re-arms the parser.
module register_write_blob_parser_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [rwbp_pkg::WORD_W-1:0] blob_length,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  blob_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [2:0]                       kind,
	output logic [15:0]                      reg_addr,
	output logic [rwbp_pkg::WORD_W-1:0]      payload_length,
	output logic [7:0]                       data_byte,
	output logic                             last_of_write,
	output logic [2:0]                       error_code,
	output logic [rwbp_pkg::WORD_W-1:0]      blob_offset
);
	import rwbp_pkg::*;

	res_pair_t pair;
	res_t      head;
	logic      room;
	logic      cfg_fire, in_fire;

	assign cfg_ready = 1'b1;
	// hold the byte while a blob_length write takes the parser
	assign in_ready  = room && !cfg_valid;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_fire   = in_valid && in_ready;

	rwbp_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_fire (cfg_fire),
		.cfg_data (blob_length),
		.in_fire  (in_fire),
		.in_byte  (blob_byte),
		.pair     (pair)
	);

	rwbp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind           = head.kind;
	assign reg_addr       = head.reg_addr;
	assign payload_length = head.payload_length;
	assign data_byte      = head.data_byte;
	assign last_of_write  = head.last_of_write;
	assign error_code     = head.error_code;
	assign blob_offset    = head.blob_offset;

endmodule
`default_nettype wire

/* sv/rwbp_parse_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rwbp_parse_core
// Parser state and the per-byte decode that yields up to two results.
// ---------------------------------------------------------------------------
module rwbp_parse_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_fire,
	input  wire logic [rwbp_pkg::WORD_W-1:0] cfg_data,
	input  wire logic                       in_fire,
	input  wire logic [7:0]                 in_byte,
	output rwbp_pkg::res_pair_t             pair
);
	import rwbp_pkg::*;

	logic [WORD_W-1:0] blen_q, pos_q, alen_q, remain_q, astart_q;
	logic [2:0]        phase_q;
	logic [7:0]        type_q;
	logic [15:0]       addr_q;
	logic              pad_q;

	logic [WORD_W-1:0] blen_d, pos_d, alen_d, remain_d, astart_d;
	logic [2:0]        phase_d;
	logic [7:0]        type_d;
	logic [15:0]       addr_d;
	logic              pad_d;

	logic [WORD_W-1:0] plen, idx, rem_dec;
	logic              fin_pad, fin_fail, trunc, at_end;
	logic [SUM_W-1:0]  fin_next;
	logic [15:0]       addr_lo;

	res_t p_res, e_res;
	logic p_vld, e_vld, do_finish;

	assign plen     = alen_q - WORD_W'(2);
	assign fin_pad  = (phase_q == PH_PAYLOAD) ? pad_q : plen[0];
	assign fin_next = SUM_W'(astart_q) + SUM_W'(ACT_LEN) + SUM_W'(plen) + SUM_W'(fin_pad);
	assign fin_fail = (fin_next + SUM_W'(ACT_LEN)) > SUM_W'(blen_q);
	assign trunc    = (SUM_W'(astart_q) + SUM_W'(ACT_LEN) + SUM_W'(plen)) > SUM_W'(blen_q);
	assign at_end   = (SUM_W'(pos_q) + SUM_W'(1)) >= SUM_W'(blen_q);
	assign idx      = pos_q - astart_q;
	assign rem_dec  = (remain_q != '0) ? remain_q - WORD_W'(1) : remain_q;
	assign addr_lo  = {addr_q[15:8], in_byte};

	always_comb begin
		blen_d    = blen_q;
		pos_d     = pos_q;
		alen_d    = alen_q;
		remain_d  = remain_q;
		astart_d  = astart_q;
		phase_d   = phase_q;
		type_d    = type_q;
		addr_d    = addr_q;
		pad_d     = pad_q;
		p_res     = '0;
		e_res     = '0;
		p_vld     = 1'b0;
		e_vld     = 1'b0;
		do_finish = 1'b0;

		if (cfg_fire) begin
			blen_d  = cfg_data;
			pos_d   = '0;
			phase_d = PH_HEADER;
			pad_d   = 1'b0;
		end else if (in_fire) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == '0 && blen_q < HEAD_LEN) begin
						p_vld   = 1'b1;
						p_res   = mk_res(KIND_ERROR, '0, '0, '0, 1'b0, ERR_HEADER, '0);
						phase_d = PH_DRAIN;
					end else if (pos_q < MAGIC_LEN && in_byte != magic_byte(pos_q[2:0])) begin
						p_vld   = 1'b1;
						p_res   = mk_res(KIND_ERROR, '0, '0, '0, 1'b0, ERR_HEADER, '0);
						phase_d = PH_DRAIN;
					end else if (pos_q >= HEAD_LEN - WORD_W'(1)) begin
						astart_d = HEAD_LEN;
						pad_d    = 1'b0;
						if (SUM_W'(HEAD_LEN) + SUM_W'(ACT_LEN) > SUM_W'(blen_q)) begin
							p_vld   = 1'b1;
							p_res   = mk_res(KIND_ERROR, '0, '0, '0, 1'b0, ERR_NO_END,
								HEAD_LEN);
							phase_d = PH_DRAIN;
						end else begin
							phase_d = PH_ACTION;
						end
					end
				end
				PH_ACTION: begin
					case (idx)
						WORD_W'(0): begin
							type_d = in_byte;
							alen_d = '0;
							if (in_byte == TYPE_END) begin
								p_vld   = 1'b1;
								p_res   = mk_res(KIND_DONE, '0, '0, '0, 1'b0, ERR_HEADER,
									astart_q);
								phase_d = PH_DRAIN;
							end
						end
						WORD_W'(1): alen_d = {in_byte, 16'h0000};
						WORD_W'(2): alen_d = {alen_q[23:8], in_byte};
						WORD_W'(3): alen_d = {alen_q[23:16], in_byte, alen_q[7:0]};
						WORD_W'(4): addr_d = {in_byte, 8'h00};
						default: begin
							addr_d = addr_lo;
							p_vld  = 1'b1;
							if (alen_q < WORD_W'(2)) begin
								p_res   = mk_res(KIND_ERROR, '0, '0, '0, 1'b0, ERR_SHORT_LEN,
									astart_q);
								phase_d = PH_DRAIN;
							end else if (trunc) begin
								p_res   = mk_res(KIND_ERROR, '0, '0, '0, 1'b0, ERR_TRUNC,
									astart_q);
								phase_d = PH_DRAIN;
							end else if (type_q > TYPE_SAFELOAD) begin
								p_res   = mk_res(KIND_ERROR, '0, '0, '0, 1'b0, ERR_TYPE,
									astart_q);
								phase_d = PH_DRAIN;
							end else begin
								p_res    = mk_res((type_q == TYPE_SAFELOAD) ? KIND_SAFELOAD
									: KIND_WRITE, addr_lo, plen, '0, 1'b0, ERR_HEADER, astart_q);
								remain_d = plen;
								pad_d    = plen[0];
								if (plen == '0) do_finish = 1'b1;
								else phase_d = PH_PAYLOAD;
							end
						end
					endcase
				end
				PH_PAYLOAD: begin
					remain_d = rem_dec;
					if (type_q != TYPE_SAFELOAD) begin
						p_vld = 1'b1;
						p_res = mk_res(KIND_PAYLOAD, addr_q, plen, in_byte, rem_dec == '0,
							ERR_HEADER, astart_q);
					end
					if (rem_dec == '0) do_finish = 1'b1;
				end
				PH_PAD: begin
					pad_d   = 1'b0;
					phase_d = PH_ACTION;
				end
				default: begin
				end
			endcase

			// close the action: step to the next head or report a missing end
			if (do_finish) begin
				if (fin_fail) begin
					e_vld   = 1'b1;
					e_res   = mk_res(KIND_ERROR, '0, '0, '0, 1'b0, ERR_NO_END,
						sat_off(fin_next));
					phase_d = PH_DRAIN;
				end else begin
					astart_d = fin_next[WORD_W-1:0];
					phase_d  = fin_pad ? PH_PAD : PH_ACTION;
				end
			end

			if (at_end) begin
				pos_d   = '0;
				phase_d = PH_HEADER;
				pad_d   = 1'b0;
			end else begin
				pos_d = pos_q + WORD_W'(1);
			end
		end
	end

	always_comb begin
		pair = '0;
		if (p_vld && e_vld) begin
			pair.count = 2'd2;
			pair.r0    = p_res;
			pair.r1    = e_res;
		end else if (p_vld) begin
			pair.count = 2'd1;
			pair.r0    = p_res;
		end else if (e_vld) begin
			pair.count = 2'd1;
			pair.r0    = e_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q   <= '0;
			pos_q    <= '0;
			alen_q   <= '0;
			remain_q <= '0;
			astart_q <= '0;
			phase_q  <= PH_HEADER;
			type_q   <= '0;
			addr_q   <= '0;
			pad_q    <= 1'b0;
		end else begin
			blen_q   <= blen_d;
			pos_q    <= pos_d;
			alen_q   <= alen_d;
			remain_q <= remain_d;
			astart_q <= astart_d;
			phase_q  <= phase_d;
			type_q   <= type_d;
			addr_q   <= addr_d;
			pad_q    <= pad_d;
		end
	end

endmodule
`default_nettype wire

/* sv/rwbp_result_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rwbp_result_fifo
// Four-entry result queue: takes up to two results a cycle, gives one.
// ---------------------------------------------------------------------------
module rwbp_result_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  rwbp_pkg::res_pair_t      pair,
	output logic                     room,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rwbp_pkg::res_t           head
);
	import rwbp_pkg::*;

	res_t       mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 3'd0);
	assign room      = (cnt_q <= 3'd2);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (pair.count != 2'd0) mem_q[wr_ptr_q] <= pair.r0;
		if (pair.count == 2'd2) mem_q[wr_ptr_q + 2'd1] <= pair.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pair.count;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(pair.count) - 3'(pop);
		end
	end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the register write blob parser. Streams firmware
// blobs byte by byte, predicts every report with a local copy of the parser
// state and checks each output beat against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
	import rwbp_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int MAX_REPORTED   = 10;
	localparam logic [55:0] SIGNATURE = "ADISIGM";

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [WORD_W-1:0] blob_length = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        blob_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        kind;
	logic [15:0]       reg_addr;
	logic [WORD_W-1:0] payload_length;
	logic [7:0]        data_byte;
	logic              last_of_write;
	logic [2:0]        error_code;
	logic [WORD_W-1:0] blob_offset;

	// parser state as the bench sees it
	logic [WORD_W-1:0] model_len = '0;
	logic [WORD_W-1:0] cur_pos = '0;
	logic [2:0]        cur_phase = PH_HEADER;
	logic [7:0]        cur_type = '0;
	logic [WORD_W-1:0] cur_alen = '0;
	logic [15:0]       cur_addr = '0;
	logic [WORD_W-1:0] cur_left = '0;
	logic [WORD_W-1:0] cur_start = '0;
	logic              cur_pad = 1'b0;

	res_t       pending_reports[$];
	logic [7:0] blob_bytes[$];

	int mismatch_count = 0;
	int idle_cycles = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;

	register_write_blob_parser_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.blob_length    (blob_length),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.blob_byte      (blob_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.reg_addr       (reg_addr),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.last_of_write  (last_of_write),
		.error_code     (error_code),
		.blob_offset    (blob_offset)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void queue_report(input logic [2:0] k, input logic [15:0] a,
		input logic [WORD_W-1:0] pl, input logic [7:0] d, input logic l,
		input logic [2:0] e, input logic [31:0] off);
		res_t r;
		r.kind           = k;
		r.reg_addr       = a;
		r.payload_length = pl;
		r.data_byte      = d;
		r.last_of_write  = l;
		r.error_code     = e;
		r.blob_offset    = (off > 32'(WORD_MAX)) ? WORD_MAX : off[WORD_W-1:0];
		pending_reports.push_back(r);
	endfunction

	function automatic void abort_blob(input logic [2:0] code, input logic [31:0] off);
		queue_report(KIND_ERROR, '0, '0, '0, 1'b0, code, off);
		cur_phase = PH_DRAIN;
	endfunction

	function automatic void rearm_parser();
		cur_pos   = '0;
		cur_phase = PH_HEADER;
		cur_pad   = 1'b0;
	endfunction

	// step to the next action head, or fail when no head fits before the end
	function automatic void close_action(input logic [31:0] len);
		logic [31:0] nxt;
		nxt = 32'(cur_start) + 32'(ACT_LEN) + 32'(cur_alen) - 32'd2 + 32'(cur_pad);
		if (nxt + 32'(ACT_LEN) > len) begin
			abort_blob(ERR_NO_END, nxt);
		end else begin
			cur_start = nxt[WORD_W-1:0];
			cur_phase = cur_pad ? PH_PAD : PH_ACTION;
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		logic [31:0]       len;
		logic [31:0]       pos;
		logic [31:0]       plen;
		logic [WORD_W-1:0] idx;
		logic              at_end;
		len    = 32'(model_len);
		pos    = 32'(cur_pos);
		at_end = (pos + 32'd1 >= len);
		idx    = cur_pos - cur_start;
		case (cur_phase)
			PH_HEADER: begin
				if (pos == 0 && len < 32'(HEAD_LEN)) begin
					abort_blob(ERR_HEADER, 32'd0);
				end else if (pos < 32'(MAGIC_LEN) && b != SIGNATURE[8*(6-pos) +: 8]) begin
					abort_blob(ERR_HEADER, 32'd0);
				end else if (pos >= 32'(HEAD_LEN) - 1) begin
					cur_start = HEAD_LEN;
					cur_pad   = 1'b0;
					if (32'(HEAD_LEN) + 32'(ACT_LEN) > len) begin
						abort_blob(ERR_NO_END, 32'(HEAD_LEN));
					end else begin
						cur_phase = PH_ACTION;
					end
				end
			end
			PH_ACTION: begin
				case (idx)
					0: begin
						cur_type = b;
						cur_alen = '0;
						if (b == TYPE_END) begin
							queue_report(KIND_DONE, '0, '0, '0, 1'b0, '0, 32'(cur_start));
							cur_phase = PH_DRAIN;
						end
					end
					1: cur_alen = {b, 16'h0000};
					2: cur_alen = cur_alen | 24'(b);
					3: cur_alen = cur_alen | {8'h00, b, 8'h00};
					4: cur_addr = {b, 8'h00};
					default: begin
						cur_addr = cur_addr | 16'(b);
						plen = 32'(cur_alen) - 32'd2;
						if (cur_alen < 2) begin
							abort_blob(ERR_SHORT_LEN, 32'(cur_start));
						end else if (32'(cur_start) + 32'(ACT_LEN) + plen > len) begin
							abort_blob(ERR_TRUNC, 32'(cur_start));
						end else if (cur_type > TYPE_SAFELOAD) begin
							abort_blob(ERR_TYPE, 32'(cur_start));
						end else begin
							queue_report((cur_type == TYPE_SAFELOAD) ? KIND_SAFELOAD : KIND_WRITE,
								cur_addr, plen[WORD_W-1:0], '0, 1'b0, '0, 32'(cur_start));
							cur_left = plen[WORD_W-1:0];
							cur_pad  = plen[0];
							if (plen == 0) begin
								close_action(len);
							end else begin
								cur_phase = PH_PAYLOAD;
							end
						end
					end
				endcase
			end
			PH_PAYLOAD: begin
				if (cur_left > 0) begin
					cur_left = cur_left - 1'b1;
				end
				// safeload bodies are skipped silently
				if (cur_type != TYPE_SAFELOAD) begin
					queue_report(KIND_PAYLOAD, cur_addr, cur_alen - 24'd2, b, cur_left == 0,
						'0, 32'(cur_start));
				end
				if (cur_left == 0) begin
					close_action(len);
				end
			end
			PH_PAD: begin
				cur_pad   = 1'b0;
				cur_phase = PH_ACTION;
			end
			default: ;
		endcase
		if (at_end) begin
			rearm_parser();
		end else begin
			cur_pos = cur_pos + 1'b1;
		end
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void flag_result(input string what, input res_t want, input res_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED) begin
			$display("%0t %s: expected kind=%0d addr=%h plen=%0d data=%h last=%0d err=%0d off=%0d",
				$time, what, want.kind, want.reg_addr, want.payload_length, want.data_byte,
				want.last_of_write, want.error_code, want.blob_offset);
			$display("%0t %s: actual   kind=%0d addr=%h plen=%0d data=%h last=%0d err=%0d off=%0d",
				$time, what, got.kind, got.reg_addr, got.payload_length, got.data_byte,
				got.last_of_write, got.error_code, got.blob_offset);
		end
	endfunction

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {kind, reg_addr, payload_length, data_byte, last_of_write, error_code,
				blob_offset};
			if (pending_reports.size() == 0) begin
				flag_result("unexpected result", '0, got);
			end else begin
				want = pending_reports.pop_front();
				if (got.kind !== want.kind || got.reg_addr !== want.reg_addr ||
					got.payload_length !== want.payload_length ||
					got.data_byte !== want.data_byte ||
					got.last_of_write !== want.last_of_write ||
					got.error_code !== want.error_code ||
					got.blob_offset !== want.blob_offset) begin
					flag_result("result mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic send_byte(input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		blob_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
		parse_byte(b);
	endtask

	// wait until every predicted report has come out and the pipe is empty
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_blob_length(input logic [WORD_W-1:0] v);
		drain_reports();
		cfg_valid   <= 1'b1;
		blob_length <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		model_len = v;
		rearm_parser();
	endtask

	task automatic stream_blob(input logic [WORD_W-1:0] len, input bit hold_output);
		write_blob_length(len);
		if (hold_output) begin
			hold_requests++;
		end
		foreach (blob_bytes[i]) begin
			send_byte(blob_bytes[i]);
		end
		blob_bytes.delete();
	endtask

	// ---------------------------------------------------------------- blob builders

	function automatic void add_header(input bit good_magic);
		int   bad_at;
		logic [7:0] c;
		bad_at = $urandom_range(6);
		for (int i = 0; i < 12; i++) begin
			c = (i < 7) ? SIGNATURE[8*(6-i) +: 8] : 8'($urandom);
			if (!good_magic && i == bad_at) begin
				c = c ^ 8'($urandom_range(1, 255));
			end
			blob_bytes.push_back(c);
		end
	endfunction

	// head with little-endian low word and big-endian address, then body bytes
	function automatic void add_action(input logic [7:0] t, input logic [23:0] alen,
		input logic [15:0] addr, input int body);
		blob_bytes.push_back(t);
		blob_bytes.push_back(alen[23:16]);
		blob_bytes.push_back(alen[7:0]);
		blob_bytes.push_back(alen[15:8]);
		blob_bytes.push_back(addr[15:8]);
		blob_bytes.push_back(addr[7:0]);
		repeat (body) blob_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_end();
		add_action(TYPE_END, 24'($urandom), 16'($urandom), 0);
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_short_blobs();
		blob_bytes = '{8'h41, 8'hFF};
		stream_blob(24'd0, 1'b0);
		blob_bytes = '{8'h41};
		stream_blob(24'd11, 1'b0);
	endtask

	task automatic test_bad_magic();
		blob_bytes = '{8'h41, 8'h44, 8'h00};
		stream_blob(24'd20, 1'b0);
	endtask

	task automatic test_no_room_after_header();
		add_header(1'b1);
		stream_blob(24'd17, 1'b0);
	endtask

	// all-ones length field and type: truncation wins over the unknown type
	task automatic test_max_length();
		add_header(1'b1);
		add_action(8'hFF, 24'hFFFFFF, 16'hFFFF, 0);
		stream_blob(WORD_MAX, 1'b0);
	endtask

	task automatic test_full_blob();
		add_header(1'b1);
		add_action(8'h00, 24'd2, 16'h0000, 0);
		add_action(8'h01, 24'd3, 16'h1234, 2);
		add_action(TYPE_SAFELOAD, 24'd4, 16'hFFFF, 2);
		add_end();
		stream_blob(24'(blob_bytes.size()), 1'b0);
	endtask

	// last payload byte also reports the missing end action
	task automatic test_no_room_after_write();
		add_header(1'b1);
		add_action(8'h00, 24'd5, 16'hA5A5, 3);
		stream_blob(24'(blob_bytes.size()), 1'b0);
	endtask

	task automatic test_output_backpressure();
		add_header(1'b1);
		add_action(8'h01, 24'd42, 16'($urandom), 40);
		add_end();
		stream_blob(24'(blob_bytes.size()), 1'b1);
	endtask

	task automatic stream_random_blob();
		int         n_act;
		int         plen;
		int         len;
		int         pick;
		logic [7:0] t;
		logic [23:0] alen;
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 24)) blob_bytes.push_back(8'($urandom));
			len = $urandom_range(0, 30);
		end else begin
			add_header($urandom_range(99) >= 8);
			n_act = $urandom_range(0, 4);
			repeat (n_act) begin
				pick = $urandom_range(99);
				plen = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
				alen = 24'(plen + 2);
				if (pick < 60) begin
					t = 8'($urandom_range(0, 1));
				end else if (pick < 80) begin
					t = TYPE_SAFELOAD;
				end else if (pick < 88) begin
					t = 8'($urandom_range(4, 255));
				end else begin
					t    = 8'($urandom_range(0, 2));
					alen = 24'($urandom_range(0, 1));
				end
				add_action(t, alen, 16'($urandom), plen + (plen % 2));
			end
			if ($urandom_range(99) < 85) begin
				add_end();
			end
			repeat ($urandom_range(0, 4)) blob_bytes.push_back(8'($urandom));
			pick = $urandom_range(99);
			if (pick < 75) begin
				len = blob_bytes.size();
			end else if (pick < 85) begin
				len = blob_bytes.size() - $urandom_range(1, 8);
			end else if (pick < 95) begin
				len = blob_bytes.size() + $urandom_range(1, 20);
			end else begin
				len = int'(WORD_MAX);
			end
		end
		if (len < 0) begin
			len = 0;
		end
		stream_blob(24'(len), 1'b0);
	endtask

	task automatic test_random_streams();
		int goal;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 83 : (ph == 3) ? 8 : 0;
			recv_stall_pct = (ph == 2) ? 83 : (ph == 3) ? 8 : 0;
			goal = bytes_sent + RANDOM_ITEMS / 4;
			while (bytes_sent < goal) stream_random_blob();
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_blobs();
		test_bad_magic();
		test_no_room_after_header();
		test_max_length();
		test_full_blob();
		test_no_room_after_write();
		test_output_backpressure();
		test_random_streams();
		drain_reports();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
